// File: rtl/c422_pkg.sv
// c422_pkg: shared constants and types for the 4:2:2 to 4:4:4 chroma upsampler.
// Used by c422_pair_gen, c422_mac_cell and chroma_422_four_tap_upsample_top.
// No dependencies.
package c422_pkg;

    localparam int C422_DATA_W    = 8;
    localparam int C422_TAP_W     = 8;
    localparam int C422_NUM_TAPS  = 4;
    localparam int C422_PSUM_W    = 19;
    localparam int C422_REC_DEPTH = 4;
    localparam int C422_ROUND     = 64;
    localparam int C422_SHIFT     = 7;
    localparam logic [C422_DATA_W-1:0] C422_MAX_VAL = 8'hFF;

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_TAP_FAR_LEFT   = 2'd0;
    localparam logic [1:0] REG_TAP_CENTER     = 2'd1;
    localparam logic [1:0] REG_TAP_NEAR_RIGHT = 2'd2;
    localparam logic [1:0] REG_TAP_FAR_RIGHT  = 2'd3;

    localparam logic [C422_TAP_W-1:0] TAP_FAR_LEFT_RST   = 8'hF7; // -9
    localparam logic [C422_TAP_W-1:0] TAP_CENTER_RST     = 8'h6F; // 111
    localparam logic [C422_TAP_W-1:0] TAP_NEAR_RIGHT_RST = 8'h1D; // 29
    localparam logic [C422_TAP_W-1:0] TAP_FAR_RIGHT_RST  = 8'hFD; // -3

    // samples already taken in the current row, saturating
    localparam logic [1:0] POS_START = 2'd0;
    localparam logic [1:0] POS_ONE   = 2'd1;
    localparam logic [1:0] POS_TWO   = 2'd2;
    localparam logic [1:0] POS_FULL  = 2'd3;

    typedef logic [C422_DATA_W-1:0] sample_t;

    // ops[0] weighs with the far-left tap, ops[3] with the far-right tap
    typedef struct packed {
        sample_t [C422_NUM_TAPS-1:0] ops;
        sample_t                     even;
        logic                        last;
    } job_t;

    // one queued input sample with the history seen before it
    typedef struct packed {
        sample_t    x;
        sample_t    s1;
        sample_t    s2;
        sample_t    s3;
        logic [1:0] pos;
        logic       row_end;
    } rec_t;

endpackage

// File: rtl/chroma_422_four_tap_upsample_top.sv
// chroma_422_four_tap_upsample_top: 4:2:2 to 4:4:4 chroma upsampler, four-tap filter.
// Channels and reset:
//   channel  | direction | payload                               | handshake
//   ---------+-----------+---------------------------------------+---------------
//   s_       | in        | chroma_sample[7:0], row_end           | s_valid/s_ready
//   m_       | out       | even_value[7:0], odd_value[7:0], row_last | m_valid/m_ready
//   apb      | cfg       | four 8-bit signed taps at 0x0..0xC    | psel/penable
// One sample per cycle sustained while s_ready and m_ready hold. m_valid rises once the
// job of a queued pair's record has passed four MAC cells and the output register; the
// further pairs of a row-end record follow one per cycle while m_ready holds.
// A row-end sample yields up to three pairs, drained from a REC_DEPTH-entry record queue
// one per cycle while the chain advances; s_ready drops only while that queue is full.
// m_ready low while m_valid is high freezes the whole cell chain. Reset restores the
// default taps and clears the row history; no memory clearing pass.
// Depends on c422_pkg, c422_pair_gen, c422_mac_cell.
module chroma_422_four_tap_upsample_top #(
    parameter int REC_DEPTH = c422_pkg::C422_REC_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  c422_pkg::sample_t s_chroma_sample,
    input  logic              s_row_end,
    output logic              m_valid,
    input  logic              m_ready,
    output c422_pkg::sample_t m_even_value,
    output c422_pkg::sample_t m_odd_value,
    output logic              m_row_last
);
    import c422_pkg::*;

    logic [C422_NUM_TAPS-1:0][C422_TAP_W-1:0] tap_reg;
    logic [1:0]                               reg_idx;

    logic                          advance;
    logic [C422_NUM_TAPS:0]        valid_chain;
    job_t                          job_chain  [C422_NUM_TAPS+1];
    logic signed [C422_PSUM_W-1:0] psum_chain [C422_NUM_TAPS+1];

    logic signed [C422_PSUM_W-1:0] rounded;
    sample_t                       odd_next;

    logic    m_valid_reg;
    sample_t m_even_reg, m_odd_reg;
    logic    m_last_reg;

    // configuration
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign prdata  = 32'(signed'(tap_reg[reg_idx]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg[REG_TAP_FAR_LEFT]   <= TAP_FAR_LEFT_RST;
            tap_reg[REG_TAP_CENTER]     <= TAP_CENTER_RST;
            tap_reg[REG_TAP_NEAR_RIGHT] <= TAP_NEAR_RIGHT_RST;
            tap_reg[REG_TAP_FAR_RIGHT]  <= TAP_FAR_RIGHT_RST;
        end else if (psel && penable && pwrite && pready) begin
            tap_reg[reg_idx] <= pwdata[C422_TAP_W-1:0];
        end
    end

    // whole datapath moves together; output register free or being drained
    assign advance = !m_valid_reg || m_ready;

    c422_pair_gen #(
        .REC_DEPTH (REC_DEPTH)
    ) u_pair_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_sample  (s_chroma_sample),
        .in_row_end (s_row_end),
        .advance    (advance),
        .job_valid  (valid_chain[0]),
        .job        (job_chain[0])
    );

    assign psum_chain[0] = '0;

    for (genvar gi = 0; gi < C422_NUM_TAPS; gi++) begin : g_cell
        c422_mac_cell #(
            .TAP_IDX (gi)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (valid_chain[gi]),
            .in_job    (job_chain[gi]),
            .in_psum   (psum_chain[gi]),
            .tap       ($signed(tap_reg[gi])),
            .out_valid (valid_chain[gi+1]),
            .out_job   (job_chain[gi+1]),
            .out_psum  (psum_chain[gi+1])
        );
    end

    // round, shift, clamp to 0..255
    assign rounded = psum_chain[C422_NUM_TAPS] + C422_PSUM_W'(C422_ROUND);

    always_comb begin
        if (rounded[C422_PSUM_W-1]) begin
            odd_next = '0;
        end else if (|rounded[C422_PSUM_W-2:C422_SHIFT+C422_DATA_W]) begin
            odd_next = C422_MAX_VAL;
        end else begin
            odd_next = rounded[C422_SHIFT+C422_DATA_W-1:C422_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= valid_chain[C422_NUM_TAPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_even_reg <= job_chain[C422_NUM_TAPS].even;
            m_odd_reg  <= odd_next;
            m_last_reg <= job_chain[C422_NUM_TAPS].last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_even_value = m_even_reg;
    assign m_odd_value  = m_odd_reg;
    assign m_row_last   = m_last_reg;

    a_chain_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(valid_chain[C422_NUM_TAPS:1]))
        else $error("cell chain moved during output stall");

endmodule

// File: rtl/c422_mac_cell.sv
// c422_mac_cell: one multiply-accumulate cell of the filter chain.
// Adds tap * ops[TAP_IDX] to the running sum and hands the job to the next cell.
// Depends on c422_pkg.
module c422_mac_cell #(
    parameter int TAP_IDX = 0
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    advance,
    input  logic                                    in_valid,
    input  c422_pkg::job_t                          in_job,
    input  logic signed [c422_pkg::C422_PSUM_W-1:0] in_psum,
    input  logic signed [c422_pkg::C422_TAP_W-1:0]  tap,
    output logic                                    out_valid,
    output c422_pkg::job_t                          out_job,
    output logic signed [c422_pkg::C422_PSUM_W-1:0] out_psum
);
    import c422_pkg::*;

    localparam int PROD_W = C422_TAP_W + C422_DATA_W + 1;

    logic                            valid_reg;
    job_t                            job_reg;
    logic signed [C422_PSUM_W-1:0]   psum_reg;
    logic signed [C422_PSUM_W-1:0]   psum_next;
    logic signed [PROD_W-1:0]        prod;

    assign prod      = tap * $signed({1'b0, in_job.ops[TAP_IDX]});
    assign psum_next = in_psum + C422_PSUM_W'(prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            job_reg  <= in_job;
            psum_reg <= psum_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_job   = job_reg;
    assign out_psum  = psum_reg;

endmodule

// File: rtl/c422_pair_gen.sv
// c422_pair_gen: sample history, record queue and pair expansion.
// Turns each input sample into zero to three filter jobs, one job per cycle while advance is high.
// Depends on c422_pkg.
module c422_pair_gen #(
    parameter int REC_DEPTH = c422_pkg::C422_REC_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  c422_pkg::sample_t in_sample,
    input  logic              in_row_end,
    input  logic              advance,
    output logic              job_valid,
    output c422_pkg::job_t    job
);
    import c422_pkg::*;

    localparam int PTR_W = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
    localparam int CNT_W = $clog2(REC_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(REC_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(REC_DEPTH);

    sample_t          s1_reg, s2_reg, s3_reg;
    logic [1:0]       pos_reg;
    rec_t             fifo_mem [REC_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [1:0]       idx_reg;

    logic       accept, push, pop, head_valid;
    rec_t       rec_in, head;
    logic [1:0] last_idx;
    sample_t    s3_eff;

    assign in_ready   = (fill_reg != CNT_FULL);
    assign accept     = in_valid && in_ready;
    // the first two samples of a row, unless one ends the row, only fill the history
    assign push       = accept && (in_row_end || pos_reg[1]);
    assign head_valid = (fill_reg != '0);
    assign head       = fifo_mem[rd_ptr_reg];

    always_comb begin
        rec_in.x       = in_sample;
        rec_in.s1      = s1_reg;
        rec_in.s2      = s2_reg;
        rec_in.s3      = s3_reg;
        rec_in.pos     = pos_reg;
        rec_in.row_end = in_row_end;
    end

    // history chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
            pos_reg <= POS_START;
        end else if (accept) begin
            if (in_row_end) begin
                s1_reg  <= '0;
                s2_reg  <= '0;
                s3_reg  <= '0;
                pos_reg <= POS_START;
            end else begin
                s1_reg  <= in_sample;
                s2_reg  <= s1_reg;
                s3_reg  <= s2_reg;
                pos_reg <= (pos_reg == POS_FULL) ? POS_FULL : pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= rec_in;
        end
    end

    always_comb begin
        if (!head.row_end) begin
            last_idx = 2'd0;
        end else begin
            unique case (head.pos)
                POS_START: last_idx = 2'd0;
                POS_ONE:   last_idx = 2'd1;
                default:   last_idx = 2'd2;
            endcase
        end
    end

    assign pop = advance && head_valid && (idx_reg == last_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
            if (advance && head_valid) begin
                idx_reg <= pop ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    // left neighbor of s2 is clamped to s2 when s2 opened the row
    assign s3_eff = (head.pos == POS_FULL) ? head.s3 : head.s2;

    always_comb begin
        job.last = head.row_end && (idx_reg == last_idx);
        priority if (!head.row_end || (idx_reg == 2'd0 && head.pos[1])) begin
            job.ops  = {head.x, head.s1, head.s2, s3_eff};
            job.even = head.s2;
        end else if (head.pos == POS_START) begin
            // one-sample row
            job.ops  = {head.x, head.x, head.x, head.x};
            job.even = head.x;
        end else if (head.pos == POS_ONE) begin
            job.ops  = {head.x, head.x, head.s1, head.s1};
            job.even = (idx_reg == 2'd0) ? head.s1 : head.x;
        end else begin
            // shifted rule for the last two positions of the row
            job.ops  = {head.x, head.x, head.s1, head.s2};
            job.even = (idx_reg == 2'd1) ? head.s1 : head.x;
        end
    end

    assign job_valid = head_valid;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_FULL)
        else $error("record queue overfilled");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (idx_reg <= last_idx))
        else $error("pair index past last pair of record");

    a_fill_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("record queue count lost a push");

endmodule
